// File: sv/swbd_pkg.sv
// Shared types and constants for the sliding-window bounding-box diagonal block.
// No dependencies; used by the top level.
package swbd_pkg;

   localparam int CFG_W          = 7;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int COORD_W        = 24;
   localparam int SUM_W          = 2 * COORD_W + 2;   // sum of three squared spans
   localparam int DIST_W         = SUM_W / 2;         // floor sqrt of SUM_W bits
   localparam int RING_W         = 3 * COORD_W;

   localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic signed [COORD_W-1:0] sample_x;
      logic signed [COORD_W-1:0] sample_y;
      logic signed [COORD_W-1:0] sample_z;
   } req_word_type;

   typedef struct packed {
      logic              window_full;
      logic [DIST_W-1:0] distance;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_SQUARE = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

// File: sv/swbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module swbd_ram #(
   parameter int WIDTH  = 72,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sliding_window_bbox_diagonal.sv
// Top level of the sliding-window bounding-box diagonal block.
// Depends on swbd_pkg and swbd_ram.
//
// Each add word stores a 3-D sample in a ring RAM; once window_length samples are held the
// block scans the window for the per-axis minimum and maximum, squares the three spans on
// one shared multiplier and takes a bit-serial integer square root. A clear word, or an add
// that leaves the window short, skips the scan and goes straight to the result hand-off. An
// add on a full window runs the scan through the single RAM read port, the span and square
// sequence, the square root (one result bit per cycle) and the hand-off of the result. One
// word is in work at a time; the next request is taken as soon as the result sits in the
// output register, even if it is still stalled.
module sliding_window_bbox_diagonal #(
   parameter int MAX_WINDOW = swbd_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  swbd_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output swbd_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_write_enable,
   input  logic [swbd_pkg::CFG_W-1:0]     csr_write_data
);

   import swbd_pkg::*;

   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int ITER_W = $clog2(DIST_W);
   localparam int REM_W  = DIST_W + 3;
   localparam int PROD_W = 2 * COORD_W;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  win_len_ff;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  iss_ff, iss_in;
   logic              rd_vld_ff;
   logic              first_ff, first_in;
   logic [2:0]        step_ff, step_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   logic signed [COORD_W-1:0] lo_ff [3];
   logic signed [COORD_W-1:0] hi_ff [3];
   logic signed [COORD_W-1:0] lo_in [3];
   logic signed [COORD_W-1:0] hi_in [3];

   logic [COORD_W-1:0] span_ff, span_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DIST_W-1:0]  root_ff, root_in;
   logic               res_full_ff, res_full_in;
   logic [DIST_W-1:0]  res_dist_ff, res_dist_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // window length as used: zero counts as one, clipped at the ring depth
   logic [CMP_W-1:0] cfg_ext;
   logic [LEN_W-1:0] eff_len;

   always_comb begin
      cfg_ext = CMP_W'(win_len_ff);
      if (cfg_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = LEN_W'(cfg_ext);
      end
   end

   logic             accept;
   logic [PTR_W-1:0] p_sel;
   logic [LEN_W-1:0] p_next;
   logic [LEN_W:0]   cnt_inc;
   logic [LEN_W-1:0] cnt_new;

   assign accept  = (state_ff == ST_IDLE) && req_valid;
   assign p_sel   = (LEN_W'(wp_ff) >= eff_len) ? '0 : wp_ff;
   assign p_next  = LEN_W'(p_sel) + LEN_W'(1);
   assign cnt_inc = (LEN_W + 1)'(cnt_ff) + (LEN_W + 1)'(1);
   assign cnt_new = (cnt_inc >= (LEN_W + 1)'(eff_len)) ? eff_len : cnt_inc[LEN_W-1:0];

   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [RING_W-1:0] ram_rd_data;

   assign ram_wr_en = accept && (req_word.req_type == REQ_ADD);
   assign ram_rd_en = (state_ff == ST_SCAN) && (iss_ff < eff_len);

   swbd_ram #(
      .WIDTH (RING_W),
      .DEPTH (MAX_WINDOW),
      .ADDR_W(PTR_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(p_sel),
      .wr_data({req_word.sample_x, req_word.sample_y, req_word.sample_z}),
      .rd_en  (ram_rd_en),
      .rd_addr(iss_ff[PTR_W-1:0]),
      .rd_data(ram_rd_data)
   );

   // span of the axis picked by the sequence step
   logic [COORD_W-1:0] span_sel;

   always_comb begin
      case (step_ff)
         3'd0:    span_sel = COORD_W'(hi_ff[0] - lo_ff[0]);
         3'd1:    span_sel = COORD_W'(hi_ff[1] - lo_ff[1]);
         3'd2:    span_sel = COORD_W'(hi_ff[2] - lo_ff[2]);
         default: span_sel = '0;
      endcase
   end

   // one restoring square-root step
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             take;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign take   = rem_sh >= trial;

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      iss_in      = iss_ff;
      first_in    = first_ff;
      step_in     = step_ff;
      iter_in     = iter_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      span_in     = span_ff;
      prod_in     = prod_ff;
      sum_in      = sum_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      res_full_in = res_full_ff;
      res_dist_in = res_dist_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_full_in = 1'b0;
               res_dist_in = '0;
               state_in    = ST_DONE;
               if (req_word.req_type == REQ_CLEAR) begin
                  wp_in  = '0;
                  cnt_in = '0;
               end else begin
                  wp_in  = (p_next >= eff_len) ? '0 : PTR_W'(p_next);
                  cnt_in = cnt_new;
                  if (cnt_new >= eff_len) begin
                     iss_in   = '0;
                     first_in = 1'b1;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               iss_in = iss_ff + LEN_W'(1);
            end
            if (rd_vld_ff) begin
               first_in = 1'b0;
               for (int a = 0; a < 3; a++) begin
                  if (first_ff || ($signed(ram_rd_data[(2-a)*COORD_W +: COORD_W]) < lo_ff[a]))
                  begin
                     lo_in[a] = $signed(ram_rd_data[(2-a)*COORD_W +: COORD_W]);
                  end
                  if (first_ff || ($signed(ram_rd_data[(2-a)*COORD_W +: COORD_W]) > hi_ff[a]))
                  begin
                     hi_in[a] = $signed(ram_rd_data[(2-a)*COORD_W +: COORD_W]);
                  end
               end
            end else if (iss_ff == eff_len) begin
               step_in  = '0;
               sum_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // span, square and accumulate overlap by one step each
            step_in = step_ff + 3'd1;
            if (step_ff < 3'd3) begin
               span_in = span_sel;
            end
            if ((step_ff >= 3'd1) && (step_ff <= 3'd3)) begin
               prod_in = span_ff * span_ff;
            end
            if ((step_ff >= 3'd2) && (step_ff <= 3'd4)) begin
               sum_in = sum_ff + SUM_W'(prod_ff);
            end
            if (step_ff == 3'd5) begin
               rad_in   = sum_ff;
               rem_in   = '0;
               root_in  = '0;
               iter_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in = rad_ff << 2;
            if (take) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[DIST_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[DIST_W-2:0], 1'b0};
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(DIST_W - 1)) begin
               res_full_in = 1'b1;
               res_dist_in = root_in;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_word_in.window_full = res_full_ff;
               rsp_word_in.distance    = res_dist_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_len_ff   <= WINDOW_RESET;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         first_ff     <= 1'b0;
         step_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            win_len_ff <= csr_write_data;
         end
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= ram_rd_en;
         first_ff     <= first_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      span_ff     <= span_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      res_full_ff <= res_full_in;
      res_dist_ff <= res_dist_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
